### rtl/temporal_history_clamp_blend_top_defines.svh
// Assertion helpers used by the top-level RTL file of the temporal history blender.
`ifndef TEMPORAL_HISTORY_CLAMP_BLEND_TOP_DEFINES_SVH
`define TEMPORAL_HISTORY_CLAMP_BLEND_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define THCB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thcb: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define THCB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thcb: next-cycle check failed");

`endif

### rtl/thcb_pkg.sv
`default_nettype none

package thcb_pkg;

  // Channel format: all ones means 1.0.
  localparam int CH_W   = 12;
  localparam int CH_MAX = (1 << CH_W) - 1;

  // Defaults for the top-level size parameters and the size registers.
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int SIZE_RESET     = 256;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  // One RGB pixel, index 0 is red.
  typedef logic [2:0][CH_W-1:0] rgb_t;

  // Luma arithmetic in Q12.16.
  localparam int LUMA_W = 28;
  localparam logic [LUMA_W-1:0] LUMA_FULL = LUMA_W'(64'(CH_MAX) * 64'd65536);

  // Alpha division. The full numerator and divisor share a factor of 2^17, which
  // leaves (7 * u / 16 + 5 * CH_MAX) / 2 divided by 5 * CH_MAX, done by reciprocal.
  localparam int ALPHA_W     = 12;
  localparam int SCALED_W    = 27;
  localparam int QNUM_W      = 26;
  localparam int RECIP_W     = 27;
  localparam int RECIP_SHIFT = 41;
  localparam longint ALPHA_DIV = 5 * CH_MAX;
  localparam logic [SCALED_W-1:0] ALPHA_BIAS = SCALED_W'(5 * CH_MAX);
  localparam logic [RECIP_W-1:0] ALPHA_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(ALPHA_DIV) - 64'd1) / 64'(ALPHA_DIV));
  localparam logic [ALPHA_W-1:0] MAX_ALPHA = ALPHA_W'(2867);

  // Blend accumulator: (4096 - a) * cur + a * hist + 2048.
  localparam int BLEND_W = 25;
  localparam logic [BLEND_W-1:0] BLEND_HALF = BLEND_W'(2048);
  localparam logic [ALPHA_W:0] ALPHA_ONE = (ALPHA_W + 1)'(4096);

  // Neighbor step codes along one axis.
  localparam logic [1:0] NB_LO  = 2'd0;
  localparam logic [1:0] NB_MID = 2'd1;
  localparam logic [1:0] NB_HI  = 2'd2;

  // Sequencer states.
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DECIDE = 8'b0000_0010,
    ST_GATHER = 8'b0000_0100,
    ST_LUMA   = 8'b0000_1000,
    ST_PREP   = 8'b0001_0000,
    ST_DIVIDE = 8'b0010_0000,
    ST_BLEND  = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_e;

  // Q0.16 luma weight of one channel.
  function automatic logic [15:0] luma_weight(input logic [1:0] chan);
    logic [15:0] w;
    case (chan)
      2'd0:    w = 16'd13933;
      2'd1:    w = 16'd46871;
      2'd2:    w = 16'd4732;
      default: w = 16'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/thcb_in_if.sv
`default_nettype none

// Input channel: one pixel or drain command per beat.
interface thcb_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [thcb_pkg::CH_W-1:0] pixel_r;
  logic [thcb_pkg::CH_W-1:0] pixel_g;
  logic [thcb_pkg::CH_W-1:0] pixel_b;

  modport source (output valid, cmd, pixel_r, pixel_g, pixel_b, input ready);
  modport sink   (input valid, cmd, pixel_r, pixel_g, pixel_b, output ready);
endinterface

`default_nettype wire

### rtl/thcb_out_if.sv
`default_nettype none

// Output channel: one stabilized pixel per beat.
interface thcb_out_if;
  logic                      valid;
  logic                      ready;
  logic [thcb_pkg::CH_W-1:0] out_r;
  logic [thcb_pkg::CH_W-1:0] out_g;
  logic [thcb_pkg::CH_W-1:0] out_b;
  logic                      frame_done;

  modport source (output valid, out_r, out_g, out_b, frame_done, input ready);
  modport sink   (input valid, out_r, out_g, out_b, frame_done, output ready);
endinterface

`default_nettype wire

### rtl/thcb_alpha_div.sv
`default_nettype none

// Blend weight alpha = floor((28672 * (FULL - t) + 5 * FULL) / (10 * FULL)).
// Both sides carry a factor of 2^17, so the quotient is the reduced numerator
// times a reciprocal of 5 * CH_MAX. The numerator is registered first, then the
// product is taken into the quotient register, and done_o rises with the quotient.
module thcb_alpha_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [thcb_pkg::LUMA_W-1:0]         t_i,
  output logic                                done_o,
  output logic [thcb_pkg::ALPHA_W-1:0]        alpha_o
);

  localparam int U7_W   = thcb_pkg::LUMA_W + 3;
  localparam int PROD_W = thcb_pkg::QNUM_W + thcb_pkg::RECIP_W;

  logic                              busy_q;
  logic                              done_q;
  logic [thcb_pkg::QNUM_W-1:0]       num_q;
  logic [thcb_pkg::ALPHA_W-1:0]      quo_q;
  logic [thcb_pkg::LUMA_W-1:0]       u_val;
  logic [U7_W-1:0]                   u7_val;
  logic [thcb_pkg::SCALED_W-1:0]     scaled_val;
  logic [PROD_W-1:0]                 prod_val;

  // Reduced numerator: (7 * u / 16 + 5 * CH_MAX) / 2, both divisions flooring.
  assign u_val      = thcb_pkg::LUMA_FULL - t_i;
  assign u7_val     = (U7_W'(u_val) << 3) - U7_W'(u_val);
  assign scaled_val = thcb_pkg::SCALED_W'(u7_val >> 4) + thcb_pkg::ALPHA_BIAS;
  assign prod_val   = PROD_W'(num_q) * PROD_W'(thcb_pkg::ALPHA_RECIP);

  // Control: the numerator is registered first, then the product.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end
  end

  // Numerator and quotient registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= scaled_val[thcb_pkg::SCALED_W-1:1];
    end else if (busy_q) begin
      quo_q <= prod_val[thcb_pkg::RECIP_SHIFT +: thcb_pkg::ALPHA_W];
    end
  end

  assign done_o  = done_q;
  assign alpha_o = quo_q;

endmodule

`default_nettype wire

### rtl/temporal_history_clamp_blend_top.sv
// Channel   Direction  Beat contents
// in_ch     sink       cmd (pixel or drain), pixel_r, pixel_g, pixel_b
// out_ch    source     out_r, out_g, out_b, frame_done
// cfg       write      cfg_we_i, cfg_idx_i (width, height), cfg_data_i
//
// A beat that produces no result only passes through the decide state. A result in the
// first frame needs the nine neighbor reads of the single-port line memory; a result with
// history adds six serial luma products, a reciprocal divide and six blend products.
// One item is in work at a time; in_ch.ready is high only while the sequencer is idle.
// A finished result sits in the output register, so a stalled out_ch only holds the
// sequencer when the next result is ready. Reset clears control state; memories are not
// cleared, since the first frame fills the history before a history read is used.
`default_nettype none
`include "temporal_history_clamp_blend_top_defines.svh"

module temporal_history_clamp_blend_top #(
  parameter int MAX_WIDTH  = thcb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = thcb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  thcb_in_if.sink                          in_ch,
  thcb_out_if.source                       out_ch,
  input  logic                             cfg_we_i,
  input  logic [thcb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [thcb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int RING   = 2 * MAX_WIDTH + 4;
  localparam int RB     = $clog2(RING);
  localparam int HDEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int HB     = $clog2(HDEPTH);
  localparam int WB     = $clog2(MAX_WIDTH + 1);
  localparam int YB     = $clog2(MAX_HEIGHT + 1);
  localparam int TB     = $clog2(HDEPTH + 1);
  localparam int PB     = $clog2(MAX_WIDTH + 3);
  localparam int SB     = RB + 2;
  localparam int RST_W  = (thcb_pkg::SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : thcb_pkg::SIZE_RESET;
  localparam int RST_H  = (thcb_pkg::SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                             : thcb_pkg::SIZE_RESET;

  thcb_pkg::state_e state_q;
  logic [3:0]       step_q;
  logic [1:0]       dx_q, dy_q;

  logic [WB-1:0]    width_q;
  logic [YB-1:0]    height_q;
  logic             hist_valid_q;
  logic [RB-1:0]    in_pos_q;
  logic [HB-1:0]    po_q;
  logic [WB-1:0]    ox_q;
  logic [YB-1:0]    oy_q;
  logic [PB-1:0]    pending_q;
  logic             out_valid_q;

  logic [RB-1:0]    out_slot_q;
  thcb_pkg::rgb_t   lo_q, hi_q, cur_q, res_q;
  logic [thcb_pkg::LUMA_W-1:0]  acc_cur_q, acc_hist_q, t_q;
  logic [thcb_pkg::BLEND_W-1:0] bacc_q;
  logic [thcb_pkg::CH_W-1:0]    out_r_q, out_g_q, out_b_q;
  logic                         out_done_q;

  // Memories.
  thcb_pkg::rgb_t ring_mem [RING];
  thcb_pkg::rgb_t ring_rd_q;
  thcb_pkg::rgb_t hist_mem [HDEPTH];
  thcb_pkg::rgb_t hist_rd_q;

  logic           in_fire, finish_fire, emit_due, div_start, div_done;
  logic [thcb_pkg::ALPHA_W-1:0] div_alpha;
  logic [TB-1:0]  total;
  logic [WB-1:0]  cfg_w_val;
  logic [YB-1:0]  cfg_h_val;
  logic [RB-1:0]  out_slot_val, ring_raddr;
  logic signed [SB-1:0] slot_s;
  logic           dx_keep, dy_keep, frame_last;
  thcb_pkg::rgb_t final_res, in_pix;

  assign total       = TB'(32'(width_q) * 32'(height_q));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign finish_fire = (state_q == thcb_pkg::ST_FINISH) && (!out_valid_q || out_ch.ready);
  assign div_start   = (state_q == thcb_pkg::ST_DIVIDE) && (step_q == 4'd0);
  assign frame_last  = 32'(po_q) == 32'(total) - 32'd1;
  assign final_res   = hist_valid_q ? res_q : cur_q;
  assign in_pix      = {in_ch.pixel_b, in_ch.pixel_g, in_ch.pixel_r};

  // A result is due once the pixel one line and one place ahead is in, or the frame is in.
  assign emit_due = (pending_q != '0) &&
                    ((32'(pending_q) >= 32'(width_q) + 32'd2) ||
                     (32'(pending_q) >= 32'(total) - 32'(po_q)));

  // Ring slot of the oldest pending pixel.
  always_comb begin
    if (32'(in_pos_q) >= 32'(pending_q)) begin
      out_slot_val = RB'(32'(in_pos_q) - 32'(pending_q));
    end else begin
      out_slot_val = RB'(32'(in_pos_q) + 32'(RING) - 32'(pending_q));
    end
  end

  // Neighbor address with edge replication.
  always_comb begin
    dy_keep = !((dy_q == thcb_pkg::NB_LO && oy_q == '0) ||
                (dy_q == thcb_pkg::NB_HI && oy_q == height_q - YB'(1)) ||
                dy_q == thcb_pkg::NB_MID);
    dx_keep = !((dx_q == thcb_pkg::NB_LO && ox_q == '0) ||
                (dx_q == thcb_pkg::NB_HI && ox_q == width_q - WB'(1)) ||
                dx_q == thcb_pkg::NB_MID);
    slot_s = $signed({2'b00, out_slot_q});
    if (dy_keep) begin
      if (dy_q == thcb_pkg::NB_LO) begin
        slot_s = slot_s - $signed(SB'(width_q));
      end else begin
        slot_s = slot_s + $signed(SB'(width_q));
      end
    end
    if (dx_keep) begin
      if (dx_q == thcb_pkg::NB_LO) begin
        slot_s = slot_s - $signed(SB'(1));
      end else begin
        slot_s = slot_s + $signed(SB'(1));
      end
    end
    if (slot_s < 0) begin
      slot_s = slot_s + $signed(SB'(RING));
    end else if (slot_s >= $signed(SB'(RING))) begin
      slot_s = slot_s - $signed(SB'(RING));
    end
    ring_raddr = RB'(slot_s);
  end

  // Size register values, out of range taken to the nearest legal size.
  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_w_val = WB'(1);
      cfg_h_val = YB'(1);
    end else begin
      cfg_w_val = (32'(cfg_data_i) > 32'(MAX_WIDTH))  ? WB'(MAX_WIDTH)  : WB'(cfg_data_i);
      cfg_h_val = (32'(cfg_data_i) > 32'(MAX_HEIGHT)) ? YB'(MAX_HEIGHT) : YB'(cfg_data_i);
    end
  end

  // Line ring: written on each pixel beat, read once per neighbor.
  always_ff @(posedge clk_i) begin
    if (in_fire && in_ch.cmd == thcb_pkg::CMD_PIXEL) begin
      ring_mem[in_pos_q] <= in_pix;
    end
    if (state_q == thcb_pkg::ST_GATHER && step_q < 4'd9) begin
      ring_rd_q <= ring_mem[ring_raddr];
    end
  end

  // History frame: read in the decide state of every beat, written back when a result is finished.
  always_ff @(posedge clk_i) begin
    if (finish_fire) begin
      hist_mem[po_q] <= final_res;
    end
    if (state_q == thcb_pkg::ST_DECIDE) begin
      hist_rd_q <= hist_mem[po_q];
    end
  end

  thcb_alpha_div u_alpha_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .t_i     (t_q),
    .done_o  (div_done),
    .alpha_o (div_alpha)
  );

  // Sequencer and frame position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= thcb_pkg::ST_IDLE;
      step_q       <= '0;
      dx_q         <= thcb_pkg::NB_LO;
      dy_q         <= thcb_pkg::NB_LO;
      width_q      <= WB'(RST_W);
      height_q     <= YB'(RST_H);
      hist_valid_q <= 1'b0;
      in_pos_q     <= '0;
      po_q         <= '0;
      ox_q         <= '0;
      oy_q         <= '0;
      pending_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        thcb_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (in_ch.cmd == thcb_pkg::CMD_PIXEL) begin
              in_pos_q  <= (in_pos_q == RB'(RING - 1)) ? '0 : in_pos_q + RB'(1);
              pending_q <= pending_q + PB'(1);
            end
            state_q <= thcb_pkg::ST_DECIDE;
          end
        end
        thcb_pkg::ST_DECIDE: begin
          step_q <= '0;
          dx_q   <= thcb_pkg::NB_LO;
          dy_q   <= thcb_pkg::NB_LO;
          state_q <= emit_due ? thcb_pkg::ST_GATHER : thcb_pkg::ST_IDLE;
        end
        thcb_pkg::ST_GATHER: begin
          if (step_q < 4'd9) begin
            if (dx_q == thcb_pkg::NB_HI) begin
              dx_q <= thcb_pkg::NB_LO;
              dy_q <= dy_q + 2'd1;
            end else begin
              dx_q <= dx_q + 2'd1;
            end
          end
          if (step_q == 4'd9) begin
            step_q  <= '0;
            state_q <= hist_valid_q ? thcb_pkg::ST_LUMA : thcb_pkg::ST_FINISH;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        thcb_pkg::ST_LUMA: begin
          if (step_q == 4'd5) begin
            step_q  <= '0;
            state_q <= thcb_pkg::ST_PREP;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        thcb_pkg::ST_PREP: begin
          step_q  <= '0;
          state_q <= thcb_pkg::ST_DIVIDE;
        end
        thcb_pkg::ST_DIVIDE: begin
          if (step_q == 4'd0) begin
            step_q <= 4'd1;
          end else if (div_done) begin
            step_q  <= '0;
            state_q <= thcb_pkg::ST_BLEND;
          end
        end
        thcb_pkg::ST_BLEND: begin
          if (step_q == 4'd5) begin
            step_q  <= '0;
            state_q <= thcb_pkg::ST_FINISH;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        thcb_pkg::ST_FINISH: begin
          if (finish_fire) begin
            out_valid_q <= 1'b1;
            pending_q   <= pending_q - PB'(1);
            if (32'(po_q) + 32'd1 >= 32'(total)) begin
              po_q         <= '0;
              ox_q         <= '0;
              oy_q         <= '0;
              hist_valid_q <= 1'b1;
            end else begin
              po_q <= po_q + HB'(1);
              if (ox_q == width_q - WB'(1)) begin
                ox_q <= '0;
                oy_q <= oy_q + YB'(1);
              end else begin
                ox_q <= ox_q + WB'(1);
              end
            end
            state_q <= thcb_pkg::ST_IDLE;
          end
        end
        default: begin
          state_q <= thcb_pkg::ST_IDLE;
        end
      endcase

      // A size write restarts the frame and drops the history.
      if (cfg_we_i) begin
        if (cfg_idx_i == thcb_pkg::CFG_FRAME_WIDTH) begin
          width_q <= cfg_w_val;
        end else begin
          height_q <= cfg_h_val;
        end
        hist_valid_q <= 1'b0;
        in_pos_q     <= '0;
        po_q         <= '0;
        ox_q         <= '0;
        oy_q         <= '0;
        pending_q    <= '0;
      end
    end
  end

  // Datapath: neighborhood min/max, luma, blend and the output register.
  always_ff @(posedge clk_i) begin : datapath
    logic [1:0]                   chan;
    logic [thcb_pkg::CH_W-1:0]    pix;
    logic [thcb_pkg::LUMA_W-1:0]  lprod, diff;
    logic [thcb_pkg::LUMA_W+1:0]  t4;
    logic [thcb_pkg::ALPHA_W:0]   coef;
    logic [thcb_pkg::BLEND_W-1:0] bprod, bsum;
    chan  = '0;
    pix   = '0;
    lprod = '0;
    diff  = '0;
    t4    = '0;
    coef  = '0;
    bprod = '0;
    bsum  = '0;
    case (state_q)
      thcb_pkg::ST_DECIDE: begin
        out_slot_q <= out_slot_val;
      end
      thcb_pkg::ST_GATHER: begin
        if (step_q == 4'd1) begin
          lo_q <= ring_rd_q;
          hi_q <= ring_rd_q;
        end else if (step_q != 4'd0) begin
          for (int c = 0; c < 3; c++) begin
            if (ring_rd_q[c] < lo_q[c]) lo_q[c] <= ring_rd_q[c];
            if (ring_rd_q[c] > hi_q[c]) hi_q[c] <= ring_rd_q[c];
          end
        end
        if (step_q == 4'd5) begin
          cur_q <= ring_rd_q;
        end
        if (step_q == 4'd9) begin
          acc_cur_q  <= '0;
          acc_hist_q <= '0;
        end
      end
      thcb_pkg::ST_LUMA: begin
        // One weighted channel per cycle: current pixel first, then history.
        if (step_q < 4'd3) begin
          chan = step_q[1:0];
          pix  = cur_q[chan];
        end else begin
          chan = 2'(step_q - 4'd3);
          pix  = hist_rd_q[chan];
        end
        lprod = thcb_pkg::LUMA_W'(thcb_pkg::luma_weight(chan)) * thcb_pkg::LUMA_W'(pix);
        if (step_q < 4'd3) begin
          acc_cur_q <= acc_cur_q + lprod;
        end else begin
          acc_hist_q <= acc_hist_q + lprod;
        end
      end
      thcb_pkg::ST_PREP: begin
        diff = (acc_cur_q > acc_hist_q) ? acc_cur_q - acc_hist_q : acc_hist_q - acc_cur_q;
        t4   = {diff, 2'b00};
        t_q  <= (t4 > (thcb_pkg::LUMA_W + 2)'(thcb_pkg::LUMA_FULL)) ? thcb_pkg::LUMA_FULL
                                                                    : thcb_pkg::LUMA_W'(t4);
      end
      thcb_pkg::ST_BLEND: begin
        // Even steps weight the current pixel, odd steps the clamped history.
        chan = 2'(step_q >> 1);
        if (!step_q[0]) begin
          coef = thcb_pkg::ALPHA_ONE - {1'b0, div_alpha};
          pix  = cur_q[chan];
        end else begin
          coef = {1'b0, div_alpha};
          pix  = hist_rd_q[chan];
          if (pix < lo_q[chan]) pix = lo_q[chan];
          if (pix > hi_q[chan]) pix = hi_q[chan];
        end
        bprod = thcb_pkg::BLEND_W'(coef) * thcb_pkg::BLEND_W'(pix);
        if (!step_q[0]) begin
          bacc_q <= thcb_pkg::BLEND_HALF + bprod;
        end else begin
          bsum        = bacc_q + bprod;
          res_q[chan] <= bsum[thcb_pkg::CH_W+11:12];
        end
      end
      default: begin
      end
    endcase
    if (finish_fire) begin
      out_r_q    <= final_res[0];
      out_g_q    <= final_res[1];
      out_b_q    <= final_res[2];
      out_done_q <= frame_last;
    end
  end

  assign in_ch.ready       = (state_q == thcb_pkg::ST_IDLE);
  assign out_ch.valid      = out_valid_q;
  assign out_ch.out_r      = out_r_q;
  assign out_ch.out_g      = out_g_q;
  assign out_ch.out_b      = out_b_q;
  assign out_ch.frame_done = out_done_q;

  // Pending pixels never exceed one line plus two.
  `THCB_ASSERT_IMP(a_pending_bound, clk_i, rst_ni, 1'b1, 32'(pending_q) <= 32'(width_q) + 32'd2)
  // The output column stays inside the line.
  `THCB_ASSERT_IMP(a_col_in_line, clk_i, rst_ni, 1'b1, ox_q < width_q)
  // The blend weight never passes 0.7.
  `THCB_ASSERT_IMP(a_alpha_range, clk_i, rst_ni, state_q == thcb_pkg::ST_BLEND, div_alpha <= thcb_pkg::MAX_ALPHA)
  // Each accepted beat is judged in the next cycle.
  `THCB_ASSERT_NXT(a_accept_decide, clk_i, rst_ni, in_ch.valid && in_ch.ready, state_q == thcb_pkg::ST_DECIDE)

endmodule

`default_nettype wire
